// ===== rtl/qsa_pkg.sv =====
// qsa_pkg: shared types, constants and rounding helpers for the int16 activation unit.
// No dependencies; qsa_sig and the top level refer to it by scoped names.
`default_nettype none

package qsa_pkg;

	typedef enum logic [1:0] {
		MODE_LOGISTIC = 2'd0,
		MODE_TANH     = 2'd1,
		MODE_RELU     = 2'd2,
		MODE_NONE     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_IN_SCALE  = 3'd1,
		REG_OUT_RECIP = 3'd2,
		REG_PARAM_A   = 3'd3,
		REG_PARAM_B   = 3'd4
	} reg_idx_t;

	localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam int unsigned EXP_TERMS = 12;
	localparam int unsigned DIV_STAGES = 8;   // 4 quotient bits per stage
	// sigmoid core: |z|, *log2e, *ln2, two stages per series term, 1+e, divider
	localparam int unsigned SIG_LAT = 3 + 2 * EXP_TERMS + 1 + DIV_STAGES;
	localparam int unsigned TAG_W = 32;

	// v / 2^sh, to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
			input int unsigned sh);
		logic [63:0] mag;
		mag = v[63] ? 64'(-v) : 64'(v);
		mag = (mag + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7fff;
		if (v < -64'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/qsa_if.sv =====
// qsa_in_if / qsa_out_if: valid-ready channels for sample words and result words.
// Depends on nothing.
`default_nettype none

interface qsa_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface qsa_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] result;
	logic               mode_error;
	modport source (output valid, output result, output mode_error, input ready);
	modport sink   (input valid, input result, input mode_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/qsa_sig.sv =====
// qsa_sig: pipelined logistic core, Q16.16 in, Q0.30 of 1/(1+exp(-|z|)) out.
// Depends on qsa_pkg. Advances on en.
`default_nettype none

module qsa_sig (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [32:0]          z,
	input  logic [qsa_pkg::TAG_W-1:0]   tag,
	output logic [30:0]                 sig_mag,
	output logic                        neg,
	output logic [qsa_pkg::TAG_W-1:0]   tag_out
);

	typedef struct packed {
		logic                      neg;
		logic [qsa_pkg::TAG_W-1:0] tag;
	} side_t;

	typedef struct packed {
		logic [29:0] u;
		logic        nbig;
		logic [4:0]  nsh;
	} hctl_t;

	side_t       side_s [qsa_pkg::SIG_LAT];
	logic [32:0] m_s1;
	logic [63:0] t_s2;
	logic [59:0] uprod;
	hctl_t       h_s3;
	hctl_t       ha_s [qsa_pkg::EXP_TERMS];
	hctl_t       hb_s [qsa_pkg::EXP_TERMS];
	logic [29:0] q_s [qsa_pkg::EXP_TERMS];
	logic [30:0] s_s [qsa_pkg::EXP_TERMS];
	logic [30:0] e_val;
	logic [31:0] d_s;
	logic [31:0] rem_s [qsa_pkg::DIV_STAGES];
	logic [31:0] quo_s [qsa_pkg::DIV_STAGES];
	logic [31:0] dd_s [qsa_pkg::DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= {z[32], tag};
			for (int i = 1; i < qsa_pkg::SIG_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// |z| never exceeds 2^32 here
	assign uprod = 60'(t_s2[45:16]) * 60'(qsa_pkg::LN2_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= z[32] ? 33'(-z) : 33'(z);
			t_s2 <= 64'(m_s1) * 64'(qsa_pkg::LOG2E_Q30);
			h_s3.u    <= uprod[59:30];
			h_s3.nbig <= (|t_s2[63:51]) || (t_s2[50:46] == 5'd31);
			h_s3.nsh  <= t_s2[50:46];
		end
	end

	// exp(-u) series: s = 1 - (u*s)/k, k from 12 down to 1; /k by reciprocal
	for (genvar j = 0; j < qsa_pkg::EXP_TERMS; j++) begin : g_horner
		localparam int unsigned K = qsa_pkg::EXP_TERMS - j;
		localparam logic [35:0] RECIP = ((36'd1 << 34) + 36'(K) - 36'd1) / 36'(K);
		hctl_t       h_in;
		logic [30:0] s_in;
		logic [60:0] us;
		logic [65:0] qm;
		if (j == 0) begin : g_first
			assign h_in = h_s3;
			assign s_in = qsa_pkg::Q30_ONE;
		end else begin : g_next
			assign h_in = hb_s[j-1];
			assign s_in = s_s[j-1];
		end
		assign us = 61'(h_in.u) * 61'(s_in);
		assign qm = 66'(q_s[j]) * 66'(RECIP);
		always_ff @(posedge clk) begin
			if (en) begin
				ha_s[j] <= h_in;
				q_s[j]  <= us[59:30];
				hb_s[j] <= ha_s[j];
				s_s[j]  <= qsa_pkg::Q30_ONE - qm[64:34];
			end
		end
	end

	assign e_val = hb_s[qsa_pkg::EXP_TERMS-1].nbig ? '0 :
		(s_s[qsa_pkg::EXP_TERMS-1] >> hb_s[qsa_pkg::EXP_TERMS-1].nsh);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s <= 32'(qsa_pkg::Q30_ONE) + 32'(e_val);
		end
	end

	// (2^60 + d/2) / d, restoring; the top bits of the dividend give 2^28 to start
	for (genvar i = 0; i < qsa_pkg::DIV_STAGES; i++) begin : g_div
		logic [31:0] rem_in;
		logic [31:0] quo_in;
		logic [31:0] d_in;
		logic [31:0] low;
		logic [32:0] rsh;
		logic [31:0] rem_w;
		logic [31:0] quo_w;
		if (i == 0) begin : g_first
			assign rem_in = 32'h1000_0000;
			assign quo_in = '0;
			assign d_in   = d_s;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign quo_in = quo_s[i-1];
			assign d_in   = dd_s[i-1];
		end
		assign low = {1'b0, d_in[31:1]};
		always_comb begin
			rem_w = rem_in;
			quo_w = quo_in;
			rsh   = '0;
			for (int b = 0; b < 4; b++) begin
				rsh = {rem_w, low[31 - 4 * i - b]};
				if (rsh >= {1'b0, d_in}) begin
					rsh   = rsh - {1'b0, d_in};
					quo_w = {quo_w[30:0], 1'b1};
				end else begin
					quo_w = {quo_w[30:0], 1'b0};
				end
				rem_w = rsh[31:0];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= rem_w;
				quo_s[i] <= quo_w;
				dd_s[i]  <= d_in;
			end
		end
	end

	assign sig_mag = quo_s[qsa_pkg::DIV_STAGES-1][30:0];
	assign neg     = side_s[qsa_pkg::SIG_LAT-1].neg;
	assign tag_out = side_s[qsa_pkg::SIG_LAT-1].tag;

endmodule

`default_nettype wire

// ===== rtl/qsymm16_activation_unit.sv =====
// qsymm16_activation_unit: top level of the int16 logistic / tanh / bounded-relu unit.
// Depends on qsa_pkg, qsa_if (qsa_in_if, qsa_out_if) and qsa_sig.
`default_nettype none

// One sample word in, one result word out, in order. The unit takes a word on
// every cycle while the output does not stall. Four stages dequantize and
// scale, the sigmoid core (series evaluation of exp with two multiplier stages
// per term plus a 4-bit-per-stage divider) adds 36 more, and five more apply
// gain, select the mode and requantize into the output register. The whole
// pipeline, bubbles included, holds while the output word waits; it only moves
// when the output is taken or the last stage is empty. Registers are written
// through cfg_we/cfg_idx/cfg_wdata with the pipeline empty, a rule for the user
// that the unit does not enforce; mode 3 gives result 0 with mode_error.
module qsymm16_activation_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [31:0]      cfg_wdata,
	qsa_in_if.sink           sample_ch,
	qsa_out_if.source        result_ch
);

	localparam int unsigned LAT     = 9 + qsa_pkg::SIG_LAT;
	localparam int unsigned SIG_OUT = 3 + qsa_pkg::SIG_LAT;

	qsa_pkg::mode_t     mode_q;
	logic [31:0]        in_scale_q;
	logic [31:0]        out_recip_q;
	logic signed [31:0] param_a_q;
	logic signed [31:0] param_b_q;

	logic [LAT-1:0]     vld_s;
	logic               en;

	logic signed [48:0] p1_s1;
	logic signed [31:0] x_s2;
	logic signed [63:0] bx_s3;
	logic signed [31:0] x_s3;
	logic signed [31:0] y_w;
	logic signed [31:0] relu_hi;
	logic signed [32:0] z_s4;
	logic signed [31:0] relu_s4;
	logic [30:0]        sig_mag;
	logic               sig_neg;
	logic [31:0]        relu_tag;
	logic [30:0]        sig31;
	logic signed [31:0] t_s5;
	logic [16:0]        vlog_s5;
	logic signed [31:0] relu_s5;
	logic signed [63:0] at_s6;
	logic [16:0]        vlog_s6;
	logic signed [31:0] relu_s6;
	logic signed [31:0] v_w;
	logic signed [31:0] v_s7;
	logic signed [63:0] p_s8;
	logic signed [15:0] res_s9;
	logic               err_s9;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= qsa_pkg::MODE_LOGISTIC;
			in_scale_q  <= 32'h0100_0000;   // 1.0 in Q8.24
			out_recip_q <= 32'h0000_1000;   // 1.0 in Q20.12
			param_a_q   <= 32'sh0001_0000;  // 1.0 in Q16.16
			param_b_q   <= 32'sh0001_0000;
		end else if (cfg_we) begin
			case (cfg_idx)
				qsa_pkg::REG_MODE:      mode_q      <= qsa_pkg::mode_t'(cfg_wdata[1:0]);
				qsa_pkg::REG_IN_SCALE:  in_scale_q  <= cfg_wdata;
				qsa_pkg::REG_OUT_RECIP: out_recip_q <= cfg_wdata;
				qsa_pkg::REG_PARAM_A:   param_a_q   <= cfg_wdata;
				qsa_pkg::REG_PARAM_B:   param_b_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// single advance for the whole pipe; a bubble at the end lets it move
	assign en = !vld_s[LAT-1] || result_ch.ready;
	assign sample_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], sample_ch.valid};
		end
	end

	// front end: dequantize to Q16.16, tanh input gain, relu bounds
	assign y_w     = qsa_pkg::sat32(qsa_pkg::rnd_shift(bx_s3, 16));
	assign relu_hi = (x_s3 > param_b_q) ? x_s3 : param_b_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1   <= $signed(sample_ch.sample) * $signed({1'b0, in_scale_q});
			x_s2    <= qsa_pkg::sat32(qsa_pkg::rnd_shift(64'(p1_s1), 8));
			bx_s3   <= param_b_q * x_s2;
			x_s3    <= x_s2;
			// tanh(w) = 2*sig(2w) - 1
			z_s4    <= (mode_q == qsa_pkg::MODE_TANH) ? {y_w, 1'b0} : 33'(x_s3);
			relu_s4 <= (param_a_q < relu_hi) ? param_a_q : relu_hi;
		end
	end

	qsa_sig u_sig (
		.clk     (clk),
		.en      (en),
		.z       (z_s4),
		.tag     (relu_s4),
		.sig_mag (sig_mag),
		.neg     (sig_neg),
		.tag_out (relu_tag)
	);

	// back end: sign fold, output gain, mode select, requantize
	assign sig31 = sig_neg ? (qsa_pkg::Q30_ONE - sig_mag) : sig_mag;

	always_comb begin
		case (mode_q)
			qsa_pkg::MODE_LOGISTIC: v_w = 32'(vlog_s6);
			qsa_pkg::MODE_TANH:     v_w = qsa_pkg::sat32(qsa_pkg::rnd_shift(at_s6, 30));
			qsa_pkg::MODE_RELU:     v_w = relu_s6;
			default:                v_w = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// 2*sig - 1 in Q30; wraps correctly since the true value fits
			t_s5    <= 32'({sig31, 1'b0}) - 32'h4000_0000;
			vlog_s5 <= 17'((32'(sig31) + 32'd8192) >> 14);
			relu_s5 <= relu_tag;
			at_s6   <= param_a_q * t_s5;
			vlog_s6 <= vlog_s5;
			relu_s6 <= relu_s5;
			v_s7    <= v_w;
			p_s8    <= v_s7 * $signed({1'b0, out_recip_q});
			res_s9  <= (mode_q == qsa_pkg::MODE_NONE) ? '0 :
				qsa_pkg::sat16(qsa_pkg::rnd_shift(p_s8, 28));
			err_s9  <= (mode_q == qsa_pkg::MODE_NONE);
		end
	end

	assign result_ch.valid      = vld_s[LAT-1];
	assign result_ch.result     = res_s9;
	assign result_ch.mode_error = err_s9;

	// unsupported mode always reports zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.mode_error |-> result_ch.result == 16'sd0)
		else $error("mode_error word with nonzero result");

	// a stalled output freezes every stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAT-1] && !result_ch.ready |=> $stable(vld_s) && $stable(res_s9))
		else $error("pipeline moved during output stall");

	// divider quotient never exceeds one in Q0.30
	a_sig_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SIG_OUT] |-> sig_mag <= qsa_pkg::Q30_ONE)
		else $error("sigmoid core out of range");

endmodule

`default_nettype wire

// ===== test/qsymm16_activation_unit_test.sv =====
// Self-checking bench for qsymm16_activation_unit: logistic, scaled tanh, bounded relu and mode 3.
// Depends on qsa_pkg, qsa_if and the unit in rtl/; predicts each result in-bench, checks in order.
`default_nettype none

module qsymm16_activation_unit_test;

	// fixed-point constants of the activation math
	localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
	localparam logic [63:0] LOG2E_FX  = 64'd1549082005;
	localparam logic [63:0] LN2_FX    = 64'd744261118;
	localparam int          SERIES_N  = 12;
	localparam int          DRAIN_CYC = 60;    // a bit over the pipeline depth
	localparam int          WDOG_MAX  = 5000;  // idle cycles before giving up

	typedef struct packed {
		logic signed [15:0] result;
		logic               mode_error;
	} act_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;

	qsa_in_if  sample_ch ();
	qsa_out_if result_ch ();

	qsymm16_activation_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch.sink),
		.result_ch (result_ch.source)
	);

	// bench copy of the register file
	qsa_pkg::mode_t cur_mode;
	logic [31:0]    cur_in_scale;
	logic [31:0]    cur_recip;
	logic [31:0]    cur_gain_a;
	logic [31:0]    cur_gain_b;

	act_word_t pending_words[$];
	int        fail_count;
	int        idle_cycles;
	int        stall_left;
	bit        steady;   // when set, neither side idles

	initial begin
		clk = 1'b0;
	end
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// v / 2^sh to nearest, ties away from zero
	function automatic logic signed [63:0] round_away(input logic signed [63:0] v, input int sh);
		logic [63:0] mag;
		mag = v[63] ? 64'(-v) : 64'(v);
		mag = (mag + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		return clamp(v, -64'sd2147483648, 64'sd2147483647);
	endfunction

	// logistic of a Q16.16 value in Q0.30: exp(-|z|) split into 2^-n * exp(-frac)
	function automatic logic [63:0] logistic_q30(input logic signed [63:0] z);
		logic [63:0] mag, t, shift_n, frac, u, s, e, d, r;
		int k;
		mag = z[63] ? 64'(-z) : 64'(z);
		if (mag > (64'd1 << 32)) mag = 64'd1 << 32;
		t = mag * LOG2E_FX;
		shift_n = t >> 46;
		frac = (t >> 16) & (ONE_Q30 - 1);
		u = (frac * LN2_FX) >> 30;
		s = ONE_Q30;
		for (k = SERIES_N; k >= 1; k--)
			s = ONE_Q30 - ((u * s) >> 30) / 64'(k);
		e = (shift_n >= 31) ? 64'd0 : (s >> shift_n);
		d = ONE_Q30 + e;
		r = ((64'd1 << 60) + d / 2) / d;
		return z[63] ? ONE_Q30 - r : r;
	endfunction

	function automatic act_word_t activate(input logic signed [15:0] sample);
		act_word_t w;
		logic signed [63:0] x, y, tq, v, ga, gb;
		ga = $signed(cur_gain_a);
		gb = $signed(cur_gain_b);
		w.result = '0;
		w.mode_error = 1'b0;
		if (cur_mode == qsa_pkg::MODE_NONE) begin
			w.mode_error = 1'b1;
			return w;
		end
		// dequantize: Q8.24 scale, drop 8 bits to land in Q16.16
		x = clamp32(round_away(64'(sample) * $signed({32'd0, cur_in_scale}), 8));
		case (cur_mode)
			qsa_pkg::MODE_LOGISTIC: begin
				v = $signed((logistic_q30(x) + 64'd8192) >> 14);
			end
			qsa_pkg::MODE_TANH: begin
				// tanh(y) = 2*sig(2y) - 1
				y = clamp32(round_away(gb * x, 16));
				tq = 2 * $signed(logistic_q30(2 * y)) - $signed(ONE_Q30);
				v = clamp32(round_away(ga * tq, 30));
			end
			default: begin
				// min taken last, so a wins when b > a
				v = (x > gb) ? x : gb;
				if (ga < v) v = ga;
			end
		endcase
		w.result = 16'(clamp(round_away(v * $signed({32'd0, cur_recip}), 28),
			-64'sd32768, 64'sd32767));
		return w;
	endfunction

	// ---------------------------------------------------------------- idling

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 45) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if (!steady && $urandom_range(0, 5) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left = gap_len();
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		act_word_t exp_w;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: result word with nothing pending: result %0d mode_error %0b",
					$time, result_ch.result, result_ch.mode_error);
				fail_count++;
			end else begin
				exp_w = pending_words.pop_front();
				if (result_ch.result !== exp_w.result) begin
					$display("%0t: result expected %0d actual %0d",
						$time, exp_w.result, result_ch.result);
					fail_count++;
				end
				if (result_ch.mode_error !== exp_w.mode_error) begin
					$display("%0t: mode_error expected %0b actual %0b",
						$time, exp_w.mode_error, result_ch.mode_error);
					fail_count++;
				end
			end
		end
	end

	// watchdog: any handshake on either side resets it
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_MAX) begin
			$display("%0t: watchdog expired, %0d words pending", $time, pending_words.size());
			$display("qsymm16_activation_unit_test: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- drivers

	// send one sample word; valid stays high afterward unless the next call opens a gap
	task automatic send_sample(input logic signed [15:0] sample);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= sample;
		do @(posedge clk); while (!sample_ch.ready);
		pending_words.push_back(activate(sample));
	endtask

	// stop sending and let the pipeline empty
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// write enable is left high; the caller drops it after the last write
	task automatic write_reg(input qsa_pkg::reg_idx_t idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			qsa_pkg::REG_MODE:      cur_mode     = qsa_pkg::mode_t'(data[1:0]);
			qsa_pkg::REG_IN_SCALE:  cur_in_scale = data;
			qsa_pkg::REG_OUT_RECIP: cur_recip    = data;
			qsa_pkg::REG_PARAM_A:   cur_gain_a   = data;
			default:                cur_gain_b   = data;
		endcase
	endtask

	task automatic set_config(input qsa_pkg::mode_t m, input logic [31:0] sc,
			input logic [31:0] rc, input logic [31:0] ga, input logic [31:0] gb);
		drain();
		write_reg(qsa_pkg::REG_MODE, 32'(m));
		write_reg(qsa_pkg::REG_IN_SCALE, sc);
		write_reg(qsa_pkg::REG_OUT_RECIP, rc);
		write_reg(qsa_pkg::REG_PARAM_A, ga);
		write_reg(qsa_pkg::REG_PARAM_B, gb);
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------- tests

	// reset values: logistic, unit scales, a = b = 1.0
	task automatic test_reset_logistic();
		send_sample(16'sh8000);
		send_sample(-16'sd1);
		send_sample(16'sd0);
		send_sample(16'sd1);
		send_sample(16'sh7fff);
		send_sample(16'sh5555);
		send_sample(16'shaaaa);
	endtask

	// logistic with a strong output gain so the curve shows up in int16
	task automatic test_logistic_shape();
		set_config(qsa_pkg::MODE_LOGISTIC, 32'h0040_0000, 32'h0100_0000,
			32'h0001_0000, 32'h0001_0000);
		send_sample(16'sd0);
		send_sample(16'sd3);
		send_sample(-16'sd3);
		send_sample(16'sd40);
	endtask

	task automatic test_tanh();
		set_config(qsa_pkg::MODE_TANH, 32'h0010_0000, 32'h0080_0000,
			32'h0002_0000, 32'h0000_8000);
		send_sample(16'sd16);
		send_sample(-16'sd16);
		send_sample(16'sh7fff);
		// gains at the extremes: everything saturates
		set_config(qsa_pkg::MODE_TANH, 32'hffff_ffff, 32'hffff_ffff,
			32'h8000_0000, 32'h7fff_ffff);
		send_sample(16'sh8000);
		send_sample(16'sd1);
	endtask

	task automatic test_relu();
		set_config(qsa_pkg::MODE_RELU, 32'h0100_0000, 32'h0000_1000,
			32'h0010_0000, 32'hfff0_0000);
		send_sample(16'sd0);
		send_sample(16'sd100);
		send_sample(-16'sd100);
		// lower bound above upper bound: a wins
		set_config(qsa_pkg::MODE_RELU, 32'h0100_0000, 32'h0000_1000,
			32'hfffe_0000, 32'h0005_0000);
		send_sample(16'sd7);
		send_sample(16'sh8000);
	endtask

	task automatic test_unsupported();
		set_config(qsa_pkg::MODE_NONE, 32'h0000_0000, 32'h0000_0000,
			32'h7fff_ffff, 32'h8000_0000);
		send_sample(16'sd1234);
		send_sample(16'sh8000);
	endtask

	function automatic logic [31:0] pick_word(input logic [31:0] typical);
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			4: return $urandom();
			default: return typical;
		endcase
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2, 3, 4: return 16'($signed($urandom_range(0, 255)) - 128);
			default: return 16'($urandom());
		endcase
	endfunction

	// random phases: each one a fresh register set and a burst of samples
	task automatic test_random(input int phases, input int per_phase);
		int p, i;
		qsa_pkg::mode_t m;
		for (p = 0; p < phases; p++) begin
			case ($urandom_range(0, 9))
				0:       m = qsa_pkg::MODE_NONE;
				1, 2, 3: m = qsa_pkg::MODE_LOGISTIC;
				4, 5, 6: m = qsa_pkg::MODE_TANH;
				default: m = qsa_pkg::MODE_RELU;
			endcase
			set_config(m,
				pick_word($urandom_range(1 << 18, 1 << 25)),
				pick_word($urandom_range(1 << 12, 1 << 26)),
				pick_word(32'($signed($urandom_range(0, 1 << 22)) - (1 << 21))),
				pick_word(32'($signed($urandom_range(0, 1 << 20)) - (1 << 19))));
			// every fourth phase runs without any idling
			steady = (p % 4 == 3);
			for (i = 0; i < per_phase; i++)
				send_sample(pick_sample());
			steady = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_idx          <= qsa_pkg::REG_MODE;
		cfg_wdata        <= '0;
		sample_ch.valid  <= 1'b0;
		sample_ch.sample <= '0;
		fail_count   = 0;
		steady       = 1'b0;
		cur_mode     = qsa_pkg::MODE_LOGISTIC;
		cur_in_scale = 32'h0100_0000;
		cur_recip    = 32'h0000_1000;
		cur_gain_a   = 32'h0001_0000;
		cur_gain_b   = 32'h0001_0000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_logistic();
		test_logistic_shape();
		test_tanh();
		test_relu();
		test_unsupported();
		test_random(14, 125);

		drain();
		if (fail_count == 0) begin
			$display("qsymm16_activation_unit_test: PASS");
		end else begin
			$display("qsymm16_activation_unit_test: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/qsa_pkg.sv
rtl/qsa_if.sv
rtl/qsa_sig.sv
rtl/qsymm16_activation_unit.sv
test/qsymm16_activation_unit_test.sv
